### sv/c1d_pkg.sv
// ----------------------------------------------------------------------------
// c1d_pkg - shared types and constants of the 1-D convolution MAC
// Field widths, opcode and register codes, and the structs that pass
// between the sequencer, the stores and the shared MAC.
// ----------------------------------------------------------------------------
`default_nettype none

package c1d_pkg;

  // default store sizes
  localparam int MAX_FILTERS_DEF  = 16;
  localparam int MAX_TAPS_DEF     = 16;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_SAMPLES_DEF  = 256;

  // results per position never exceed this
  localparam int RESULT_CAP = 16;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int VALUE_W    = 16;
  localparam int IDXA_W     = 8;
  localparam int IDXB_W     = 4;
  localparam int IDXC_W     = 3;
  localparam int FIDX_W     = 4;
  localparam int SUM_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // window arithmetic: pos(8b) * stride(5b), + taps, * channels
  localparam int STRIDE_W = 5;
  localparam int START_W  = 13;
  localparam int END_W    = 14;
  localparam int ENDCH_W  = 20;

  // opcodes
  localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
  localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTERS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd4;

  // store write request, taken from an accepted load item
  typedef struct packed {
    logic               en;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [IDXA_W-1:0]  idx_a;
    logic [IDXB_W-1:0]  idx_b;
    logic [IDXC_W-1:0]  idx_c;
  } load_t;

  // MAC control from the sequencer
  typedef struct packed {
    logic load_bias;  // bias read data valid: seed accumulator
    logic mul_en;     // weight and sample read data valid
    logic round;      // accumulator final: round and saturate
  } mac_ctrl_t;

endpackage

`default_nettype wire

### sv/c1d_if.sv
// ----------------------------------------------------------------------------
// c1d_if - valid/ready channels of the 1-D convolution MAC
// Input channel carries load and compute items, output channel results.
// ----------------------------------------------------------------------------
`default_nettype none

interface c1d_in_if;
  logic                                valid;
  logic                                ready;
  logic [c1d_pkg::OP_W-1:0]            opcode;
  logic signed [c1d_pkg::VALUE_W-1:0]  value;
  logic [c1d_pkg::IDXA_W-1:0]          index_a;
  logic [c1d_pkg::IDXB_W-1:0]          index_b;
  logic [c1d_pkg::IDXC_W-1:0]          index_c;

  modport source (output valid, output opcode, output value, output index_a,
                  output index_b, output index_c, input ready);
  modport sink   (input valid, input opcode, input value, input index_a,
                  input index_b, input index_c, output ready);
endinterface

interface c1d_out_if;
  logic                              valid;
  logic                              ready;
  logic [c1d_pkg::FIDX_W-1:0]        filter_index;
  logic signed [c1d_pkg::SUM_W-1:0]  sum_value;
  logic                              last_of_run;
  logic                              range_error;

  modport source (output valid, output filter_index, output sum_value,
                  output last_of_run, output range_error, input ready);
  modport sink   (input valid, input filter_index, input sum_value,
                  input last_of_run, input range_error, output ready);
endinterface

`default_nettype wire

### sv/c1d_mem.sv
// ----------------------------------------------------------------------------
// c1d_mem - weight, bias and sample stores
// Decodes load items into store writes, registered reads for the MAC,
// and zeroes the sample store in a sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module c1d_mem #(
  parameter int  MAX_FILTERS  = c1d_pkg::MAX_FILTERS_DEF,
  parameter int  MAX_TAPS     = c1d_pkg::MAX_TAPS_DEF,
  parameter int  MAX_CHANNELS = c1d_pkg::MAX_CHANNELS_DEF,
  parameter int  MAX_SAMPLES  = c1d_pkg::MAX_SAMPLES_DEF,
  localparam int WDEPTH       = MAX_FILTERS * MAX_TAPS * MAX_CHANNELS,
  localparam int WAW          = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
  localparam int BAW          = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1,
  localparam int SAW          = $clog2(MAX_SAMPLES)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  c1d_pkg::load_t                      load_i,
  input  logic [WAW-1:0]                      w_raddr_i,
  input  logic [BAW-1:0]                      b_raddr_i,
  input  logic [SAW-1:0]                      s_raddr_i,
  output logic signed [c1d_pkg::VALUE_W-1:0]  w_rdata_o,
  output logic signed [c1d_pkg::VALUE_W-1:0]  b_rdata_o,
  output logic signed [c1d_pkg::VALUE_W-1:0]  s_rdata_o,
  output logic                                clr_busy_o
);
  import c1d_pkg::*;

  logic [VALUE_W-1:0] w_mem [WDEPTH];
  logic [VALUE_W-1:0] b_mem [MAX_FILTERS];
  logic [VALUE_W-1:0] s_mem [MAX_SAMPLES];

  logic               w_we, b_we, s_ld_we, s_we;
  logic [WAW-1:0]     w_waddr;
  logic [BAW-1:0]     b_waddr;
  logic [SAW-1:0]     s_waddr;
  logic [VALUE_W-1:0] s_wdata;

  logic               clr_busy_q;
  logic [SAW-1:0]     clr_addr_q;

  // load decode; writes beyond a store are dropped
  always_comb begin
    w_we    = 1'b0;
    b_we    = 1'b0;
    s_ld_we = 1'b0;
    w_waddr = WAW'((int'(load_i.idx_a) * MAX_TAPS + int'(load_i.idx_b)) * MAX_CHANNELS
                   + int'(load_i.idx_c));
    b_waddr = BAW'(load_i.idx_a);
    if (load_i.en) begin
      case (load_i.op)
        OP_WEIGHT: begin
          w_we = (int'(load_i.idx_a) < MAX_FILTERS) && (int'(load_i.idx_b) < MAX_TAPS)
                 && (int'(load_i.idx_c) < MAX_CHANNELS);
        end
        OP_BIAS: begin
          b_we = int'(load_i.idx_a) < MAX_FILTERS;
        end
        OP_SAMPLE: begin
          s_ld_we = int'(load_i.idx_a) < MAX_SAMPLES;
        end
        default: ;
      endcase
    end
  end

  // clearing sweep takes the sample write port
  assign s_we    = clr_busy_q | s_ld_we;
  assign s_waddr = clr_busy_q ? clr_addr_q : SAW'(load_i.idx_a);
  assign s_wdata = clr_busy_q ? '0 : load_i.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == SAW'(MAX_SAMPLES - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + SAW'(1);
      end
    end
  end

  assign clr_busy_o = clr_busy_q;

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_waddr] <= load_i.value;
    end
    w_rdata_o <= w_mem[w_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= load_i.value;
    end
    b_rdata_o <= b_mem[b_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    s_rdata_o <= s_mem[s_raddr_i];
  end

endmodule

`default_nettype wire

### sv/c1d_mac.sv
// ----------------------------------------------------------------------------
// c1d_mac - shared multiply-accumulate unit
// Registered 16x16 product, wide accumulator seeded with the bias,
// then rounding to Q16.16 with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module c1d_mac #(
  parameter int ACC_W = 41
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  c1d_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [c1d_pkg::VALUE_W-1:0]  bias_i,
  input  logic signed [c1d_pkg::VALUE_W-1:0]  weight_i,
  input  logic signed [c1d_pkg::VALUE_W-1:0]  sample_i,
  output logic                                busy_o,
  output logic signed [c1d_pkg::SUM_W-1:0]    result_o
);
  import c1d_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;
  localparam logic signed [ACC_W:0] SAT_HI = {{(ACC_W-30){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO = {{(ACC_W-30){1'b1}}, {31{1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  res_q;
  logic signed [ACC_W:0]    rnd_sum;
  logic signed [ACC_W:0]    rnd_shr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  // Q4.12 bias aligned to Q8.24
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= weight_i * sample_i;
    end
    if (ctrl_i.load_bias) begin
      acc_q <= {{(ACC_W-VALUE_W-12){bias_i[VALUE_W-1]}}, bias_i, 12'b0};
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // halves go up: floor((acc + 128) / 256)
  always_comb begin
    rnd_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(128);
    rnd_shr = rnd_sum >>> 8;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.round) begin
      if (rnd_shr > SAT_HI) begin
        res_q <= SAT_HI[SUM_W-1:0];
      end else if (rnd_shr < SAT_LO) begin
        res_q <= SAT_LO[SUM_W-1:0];
      end else begin
        res_q <= rnd_shr[SUM_W-1:0];
      end
    end
  end

  assign busy_o   = prod_vld_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### sv/conv1d_multichannel_mac.sv
// ----------------------------------------------------------------------------
// conv1d_multichannel_mac - 1-D multichannel convolution layer
// Load items fill weight, bias and sample stores; a compute item runs
// one shared MAC over taps and channels for every filter of a position.
// ----------------------------------------------------------------------------
//
//  channel   dir   transfer when         carries
//  -------   ---   -------------------   ---------------------------------------
//  in_ch     in    valid & ready         opcode, value, index_a/b/c
//  out_ch    out   valid & ready         filter_index, sum_value, last, error
//  cfg       in    cfg_we_i              cfg_idx_i, cfg_wdata_i (no handshake)
//
//  Load item: written in the accept cycle, the block stays idle. Compute item:
//  the single MAC (one product per cycle) walks taps and channels per filter.
//  Out of range window: one error result.
//  After reset the sample store is zeroed, with in_ch.ready low.
//  A stalled output holds its result; the sequencer waits before the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module conv1d_multichannel_mac #(
  parameter int MAX_FILTERS  = c1d_pkg::MAX_FILTERS_DEF,
  parameter int MAX_TAPS     = c1d_pkg::MAX_TAPS_DEF,
  parameter int MAX_CHANNELS = c1d_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_SAMPLES  = c1d_pkg::MAX_SAMPLES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [c1d_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [c1d_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  c1d_in_if.sink                           in_ch,
  c1d_out_if.source                        out_ch
);
  import c1d_pkg::*;

  // store address widths
  localparam int WDEPTH = MAX_FILTERS * MAX_TAPS * MAX_CHANNELS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int BAW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int SAW    = $clog2(MAX_SAMPLES);
  // weight address step per filter
  localparam int WF_STEP = MAX_TAPS * MAX_CHANNELS;
  // filters per position
  localparam int NF_MAX = (MAX_FILTERS < RESULT_CAP) ? MAX_FILTERS : RESULT_CAP;
  // count widths, each holds its maximum
  localparam int CW  = $clog2(MAX_CHANNELS + 1);
  localparam int KW  = $clog2(MAX_TAPS + 1);
  localparam int FCW = $clog2(NF_MAX + 1);
  // accumulator: Q8.24 products times taps*channels, plus bias and sign
  localparam int ACC_W = 2 * VALUE_W + $clog2(MAX_TAPS * MAX_CHANNELS + 1) + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL1  = 10'b00_0000_0010,  // start = position * stride
    S_MUL2  = 10'b00_0000_0100,  // window end, end * channels, sample base
    S_CHECK = 10'b00_0000_1000,  // window fit
    S_ERR   = 10'b00_0001_0000,  // send error result
    S_BIAS  = 10'b00_0010_0000,  // read bias, reset tap/channel walk
    S_RUN   = 10'b00_0100_0000,  // one weight/sample pair per cycle
    S_DRAIN = 10'b00_1000_0000,  // wait for read and product stages
    S_ROUND = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [3:0] cfg_ch_q;
  logic [4:0] cfg_nf_q;
  logic [4:0] cfg_nk_q;
  logic [4:0] cfg_st_q;
  logic [8:0] cfg_len_q;

  // clamped settings for the current item
  logic [CW-1:0]       nch_d, nch_q;
  logic [KW-1:0]       nk_d, nk_q;
  logic [FCW-1:0]      nf_d, nf_q;
  logic [STRIDE_W-1:0] st_d, st_q;

  // window arithmetic
  logic [IDXA_W-1:0]   pos_q;
  logic [START_W-1:0]  start_q;
  logic [END_W-1:0]    end_w;
  logic [END_W-1:0]    end_q;
  logic [ENDCH_W-1:0]  endch_q;
  logic [ENDCH_W-1:0]  sbase_w;
  logic [SAW-1:0]      sbase_q;

  // walk counters and addresses
  logic [FCW-1:0] f_q;
  logic [KW-1:0]  t_q;
  logic [CW-1:0]  c_q;
  logic [WAW-1:0] w_f_q, w_row_q, w_addr_q;
  logic [SAW-1:0] s_addr_q;

  // MAC pipeline tags
  logic issue_q;
  logic bias_ld_q;

  // output register
  logic                     out_vld_q;
  logic [FIDX_W-1:0]        out_fidx_q;
  logic signed [SUM_W-1:0]  out_sum_q;
  logic                     out_last_q;
  logic                     out_err_q;
  logic                     out_free;

  logic                     in_fire;
  logic                     clr_busy;
  logic                     mac_busy;
  logic                     win_bad;
  logic                     last_c, last_t, last_f;
  load_t                    load;
  mac_ctrl_t                mac_ctrl;
  logic signed [VALUE_W-1:0] w_rdata, b_rdata, s_rdata;
  logic signed [SUM_W-1:0]   mac_res;

  // ---------------------------------------------------------------------------
  // Configuration writes: the user makes them only while idle; the block itself does not enforce it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ch_q  <= 4'd1;
      cfg_nf_q  <= 5'd1;
      cfg_nk_q  <= 5'd1;
      cfg_st_q  <= 5'd1;
      cfg_len_q <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNELS: cfg_ch_q  <= cfg_wdata_i[3:0];
        CFG_FILTERS:  cfg_nf_q  <= cfg_wdata_i[4:0];
        CFG_TAPS:     cfg_nk_q  <= cfg_wdata_i[4:0];
        CFG_STRIDE:   cfg_st_q  <= cfg_wdata_i[4:0];
        CFG_LENGTH:   cfg_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Counts clamped to what the stores hold, filters also to RESULT_CAP; zero settings act as one
  always_comb begin
    if (cfg_ch_q == '0) begin
      nch_d = CW'(1);
    end else if (int'(cfg_ch_q) > MAX_CHANNELS) begin
      nch_d = CW'(MAX_CHANNELS);
    end else begin
      nch_d = CW'(cfg_ch_q);
    end
    if (cfg_nk_q == '0) begin
      nk_d = KW'(1);
    end else if (int'(cfg_nk_q) > MAX_TAPS) begin
      nk_d = KW'(MAX_TAPS);
    end else begin
      nk_d = KW'(cfg_nk_q);
    end
    if (cfg_nf_q == '0) begin
      nf_d = FCW'(1);
    end else if (int'(cfg_nf_q) > NF_MAX) begin
      nf_d = FCW'(NF_MAX);
    end else begin
      nf_d = FCW'(cfg_nf_q);
    end
    st_d = (cfg_st_q == '0) ? STRIDE_W'(1) : cfg_st_q;
  end

  // ---------------------------------------------------------------------------
  // Input side: loads write the stores in the accept cycle
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_q == S_IDLE) && !clr_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    load.en    = in_fire && (in_ch.opcode != OP_COMPUTE);
    load.op    = in_ch.opcode;
    load.value = in_ch.value;
    load.idx_a = in_ch.index_a;
    load.idx_b = in_ch.index_b;
    load.idx_c = in_ch.index_c;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_vld_q || out_ch.ready;
  assign last_c   = (c_q == nch_q - CW'(1));
  assign last_t   = (t_q == nk_q - KW'(1));
  assign last_f   = (f_q == nf_q - FCW'(1));
  assign win_bad  = (end_q > END_W'(cfg_len_q)) || (endch_q > ENDCH_W'(MAX_SAMPLES));
  assign end_w    = END_W'(start_q) + END_W'(nk_q);
  assign sbase_w  = ENDCH_W'(start_q) * ENDCH_W'(nch_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire && in_ch.opcode == OP_COMPUTE) state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_CHECK;
      S_CHECK: state_d = win_bad ? S_ERR : S_BIAS;
      S_ERR:   if (out_free) state_d = S_IDLE;
      S_BIAS:  state_d = S_RUN;
      S_RUN:   if (last_c && last_t) state_d = S_DRAIN;
      S_DRAIN: if (!issue_q && !mac_busy) state_d = S_ROUND;
      S_ROUND: state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = last_f ? S_IDLE : S_BIAS;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issue_q   <= 1'b0;
      bias_ld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= (state_q == S_RUN);
      bias_ld_q <= (state_q == S_BIAS);
    end
  end

  // Window set-up and the tap/channel walk. Sample addresses run linearly
  // from start*nch, since channels are interleaved per position.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          pos_q <= in_ch.index_a;
          nch_q <= nch_d;
          nk_q  <= nk_d;
          nf_q  <= nf_d;
          st_q  <= st_d;
        end
      end
      S_MUL1: begin
        start_q <= START_W'(pos_q) * START_W'(st_q);
      end
      S_MUL2: begin
        end_q   <= end_w;
        endch_q <= ENDCH_W'(end_w) * ENDCH_W'(nch_q);
        sbase_q <= SAW'(sbase_w);
      end
      S_CHECK: begin
        f_q   <= '0;
        w_f_q <= '0;
      end
      S_BIAS: begin
        t_q      <= '0;
        c_q      <= '0;
        w_row_q  <= w_f_q;
        w_addr_q <= w_f_q;
        s_addr_q <= sbase_q;
      end
      S_RUN: begin
        s_addr_q <= s_addr_q + SAW'(1);
        if (last_c) begin
          c_q      <= '0;
          t_q      <= t_q + KW'(1);
          w_row_q  <= w_row_q + WAW'(MAX_CHANNELS);
          w_addr_q <= w_row_q + WAW'(MAX_CHANNELS);
        end else begin
          c_q      <= c_q + CW'(1);
          w_addr_q <= w_addr_q + WAW'(1);
        end
      end
      S_EMIT: begin
        if (out_free && !last_f) begin
          f_q   <= f_q + FCW'(1);
          w_f_q <= w_f_q + WAW'(WF_STEP);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == S_EMIT || state_q == S_ERR) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (state_q == S_EMIT) begin
        out_fidx_q <= FIDX_W'(f_q);
        out_sum_q  <= mac_res;
        out_last_q <= last_f;
        out_err_q  <= 1'b0;
      end else if (state_q == S_ERR) begin
        out_fidx_q <= '0;
        out_sum_q  <= '0;
        out_last_q <= 1'b1;
        out_err_q  <= 1'b1;
      end
    end
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.filter_index = out_fidx_q;
  assign out_ch.sum_value    = out_sum_q;
  assign out_ch.last_of_run  = out_last_q;
  assign out_ch.range_error  = out_err_q;

  // ---------------------------------------------------------------------------
  // Stores and shared MAC
  // ---------------------------------------------------------------------------
  always_comb begin
    mac_ctrl.load_bias = bias_ld_q;
    mac_ctrl.mul_en    = issue_q;
    mac_ctrl.round     = (state_q == S_ROUND);
  end

  c1d_mem #(
    .MAX_FILTERS  (MAX_FILTERS),
    .MAX_TAPS     (MAX_TAPS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .w_raddr_i  (w_addr_q),
    .b_raddr_i  (BAW'(f_q)),
    .s_raddr_i  (s_addr_q),
    .w_rdata_o  (w_rdata),
    .b_rdata_o  (b_rdata),
    .s_rdata_o  (s_rdata),
    .clr_busy_o (clr_busy)
  );

  c1d_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .bias_i   (b_rdata),
    .weight_i (w_rdata),
    .sample_i (s_rdata),
    .busy_o   (mac_busy),
    .result_o (mac_res)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.range_error |->
      out_ch.last_of_run && out_ch.sum_value == '0 && out_ch.filter_index == '0)
    else $error("error result with non-zero payload");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> !issue_q && !mac_busy)
    else $error("rounding before the MAC pipeline drained");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && out_free |=>
      out_ch.valid && !out_ch.range_error && out_ch.filter_index == FIDX_W'($past(f_q)))
    else $error("filter result not presented after emit");

  a_no_load_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !load.en && state_q == S_IDLE)
    else $error("activity during sample store clearing");
`endif

endmodule

`default_nettype wire

### bench/conv1d_sum_board.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv1d_sum_board - expected-result tracker for the 1-D convolution MAC
// Keeps its own copy of the weight, bias and sample stores and of the layer
// registers, works out the filter sums of every compute item and checks the
// results from the block in order.
// ----------------------------------------------------------------------------
package conv1d_sum_board_pkg;
  import c1d_pkg::*;

  localparam int WEIGHT_DEPTH = MAX_FILTERS_DEF * MAX_TAPS_DEF * MAX_CHANNELS_DEF;
  localparam int FILTER_LIMIT = (MAX_FILTERS_DEF < RESULT_CAP) ? MAX_FILTERS_DEF : RESULT_CAP;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [FIDX_W-1:0]       filter_index;
    logic signed [SUM_W-1:0] sum_value;
    logic                    last_of_run;
    logic                    range_error;
  } filter_sum_t;

  // fixed weight layout: (filter, tap, channel)
  function automatic int weight_addr(int f, int t, int c);
    return (f * MAX_TAPS_DEF + t) * MAX_CHANNELS_DEF + c;
  endfunction

  class conv_sum_board;
    logic [VALUE_W-1:0] weight_mem [WEIGHT_DEPTH];
    logic [VALUE_W-1:0] bias_mem   [MAX_FILTERS_DEF];
    logic [VALUE_W-1:0] sample_mem [MAX_SAMPLES_DEF];

    logic [3:0] reg_channels;
    logic [4:0] reg_filters;
    logic [4:0] reg_taps;
    logic [4:0] reg_stride;
    logic [8:0] reg_length;

    filter_sum_t expected_sums [$];
    int unsigned fail_count;

    function new();
      foreach (weight_mem[i]) weight_mem[i] = '0;
      foreach (bias_mem[i]) bias_mem[i] = '0;
      foreach (sample_mem[i]) sample_mem[i] = '0;
      reg_channels = 4'd1;
      reg_filters  = 5'd1;
      reg_taps     = 5'd1;
      reg_stride   = 5'd1;
      reg_length   = 9'd1;
      fail_count   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHANNELS: reg_channels = data[3:0];
        CFG_FILTERS:  reg_filters  = data[4:0];
        CFG_TAPS:     reg_taps     = data[4:0];
        CFG_STRIDE:   reg_stride   = data[4:0];
        CFG_LENGTH:   reg_length   = data;
        default: ;
      endcase
    endfunction

    function int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // register values as the datapath sees them
    function int used_channels();
      return clamp_int(int'(reg_channels), 1, MAX_CHANNELS_DEF);
    endfunction

    function int used_filters();
      return clamp_int(int'(reg_filters), 1, FILTER_LIMIT);
    endfunction

    function int used_taps();
      return clamp_int(int'(reg_taps), 1, MAX_TAPS_DEF);
    endfunction

    function int used_stride();
      return (reg_stride == 5'd0) ? 1 : int'(reg_stride);
    endfunction

    function bit window_fits(int pos);
      int stop;
      stop = pos * used_stride() + used_taps();
      return (stop <= int'(reg_length)) && (stop * used_channels() <= MAX_SAMPLES_DEF);
    endfunction

    function void predict_sums(int pos);
      filter_sum_t r;
      longint      acc;
      int          base;
      int          nch;
      int          nf;
      int          nk;
      nch = used_channels();
      nf  = used_filters();
      nk  = used_taps();
      if (!window_fits(pos)) begin
        r = '0;
        r.last_of_run = 1'b1;
        r.range_error = 1'b1;
        expected_sums.push_back(r);
        return;
      end
      base = pos * used_stride();
      for (int f = 0; f < nf; f++) begin
        // Q4.12 bias lifted to Q8.24, products are Q8.24 already
        acc = longint'($signed(bias_mem[f])) * 4096;
        for (int t = 0; t < nk; t++) begin
          for (int c = 0; c < nch; c++) begin
            acc += longint'($signed(weight_mem[weight_addr(f, t, c)])) *
                   longint'($signed(sample_mem[(base + t) * nch + c]));
          end
        end
        // to Q16.16, halves upward, then saturate
        acc = (acc + 128) >>> 8;
        if (acc > SUM_MAX) acc = SUM_MAX;
        if (acc < SUM_MIN) acc = SUM_MIN;
        r.filter_index = FIDX_W'(f);
        r.sum_value    = acc[SUM_W-1:0];
        r.last_of_run  = (f == nf - 1);
        r.range_error  = 1'b0;
        expected_sums.push_back(r);
      end
    endfunction

    function void accept_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [IDXA_W-1:0] ia, logic [IDXB_W-1:0] ib,
                              logic [IDXC_W-1:0] ic);
      case (op)
        OP_WEIGHT:
          if (ia < MAX_FILTERS_DEF && ib < MAX_TAPS_DEF && ic < MAX_CHANNELS_DEF)
            weight_mem[weight_addr(ia, ib, ic)] = value;
        OP_BIAS:    if (ia < MAX_FILTERS_DEF) bias_mem[ia] = value;
        OP_SAMPLE:  if (ia < MAX_SAMPLES_DEF) sample_mem[ia] = value;
        OP_COMPUTE: predict_sums(int'(ia));
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    function void flag_mismatch(string field, logic signed [63:0] want,
                                logic signed [63:0] got);
      fail_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_sum(logic [FIDX_W-1:0] fidx, logic signed [SUM_W-1:0] sum,
                            logic last_flag, logic error_flag);
      filter_sum_t want;
      if (expected_sums.size() == 0) begin
        fail_count++;
        $error("unexpected result: filter_index %0d sum_value %0d", fidx, sum);
        return;
      end
      want = expected_sums.pop_front();
      if (fidx !== want.filter_index)
        flag_mismatch("filter_index", want.filter_index, fidx);
      if (sum !== want.sum_value)
        flag_mismatch("sum_value", $signed(want.sum_value), sum);
      if (last_flag !== want.last_of_run)
        flag_mismatch("last_of_run", want.last_of_run, last_flag);
      if (error_flag !== want.range_error)
        flag_mismatch("range_error", want.range_error, error_flag);
    endfunction

    function void close_out();
      if (expected_sums.size() != 0) begin
        fail_count += expected_sums.size();
        $error("%0d expected results never arrived", expected_sums.size());
      end
    endfunction
  endclass

endpackage

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - bench for conv1d_multichannel_mac
// Drives load and compute items over the input channel, programs the layer
// registers between phases and checks every filter sum against a predictor
// that mirrors the stores; random gaps on both channels, none at the end.
// ----------------------------------------------------------------------------
module tb;
  import c1d_pkg::*;
  import conv1d_sum_board_pkg::*;

  // cycles without any transfer or register write before giving up
  localparam int IDLE_LIMIT    = 20000;
  // headroom for a trailing load item to retire
  localparam int SETTLE_CYCLES = 16;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 16'h8000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'h7FFF;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  c1d_in_if  in_ch ();
  c1d_out_if out_ch ();

  conv1d_multichannel_mac uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  conv_sum_board sum_board;

  // random gaps on both channels while set
  bit          idle_on;
  int unsigned idle_cycles = 0;

  // entries the bench has written; computes must never read anything else
  bit weight_known [WEIGHT_DEPTH];
  bit bias_known   [MAX_FILTERS_DEF];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Result side: ready is dropped in random bursts, changed at the
  // falling edge so the block sees it settled at the next rising edge.
  // --------------------------------------------------------------------------
  initial begin : ready_driver
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and watchdog. Sampling at the rising edge sees the values
  // from before the edge's updates, so the order of processes does not matter.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sum_board.check_sum(out_ch.filter_index, out_ch.sum_value,
                          out_ch.last_of_run, out_ch.range_error);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // full-scale values turn up more often than a flat draw would give
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // One item over the input channel. valid stays high between back-to-back
  // items; a random gap drops it first.
  task automatic send_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                           logic [IDXA_W-1:0] ia, logic [IDXB_W-1:0] ib,
                           logic [IDXC_W-1:0] ic);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.value   <= value;
    in_ch.index_a <= ia;
    in_ch.index_b <= ib;
    in_ch.index_c <= ic;
    do @(posedge clk_i); while (!in_ch.ready);
    // transfer taken at this edge
    sum_board.accept_item(op, value, ia, ib, ic);
    if (op == OP_WEIGHT && ia < MAX_FILTERS_DEF)
      weight_known[weight_addr(ia, ib, ic)] = 1'b1;
    if (op == OP_BIAS && ia < MAX_FILTERS_DEF)
      bias_known[ia] = 1'b1;
  endtask

  // Stop sending and let every outstanding sum come out, then let a trailing
  // load item retire.
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sum_board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high so that writes run back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sum_board.write_reg(idx, data);
  endtask

  // Write any weight or bias the current layer shape would read and that
  // has not been written yet.
  task automatic fill_stores();
    int nf;
    int nk;
    int nch;
    nf  = sum_board.used_filters();
    nk  = sum_board.used_taps();
    nch = sum_board.used_channels();
    for (int f = 0; f < nf; f++) begin
      if (!bias_known[f])
        send_item(OP_BIAS, pick_value(), IDXA_W'(f), IDXB_W'($urandom), IDXC_W'($urandom));
      for (int t = 0; t < nk; t++) begin
        for (int c = 0; c < nch; c++) begin
          if (!weight_known[weight_addr(f, t, c)])
            send_item(OP_WEIGHT, pick_value(), IDXA_W'(f), IDXB_W'(t), IDXC_W'(c));
        end
      end
    end
  endtask

  // Block idle on entry. Raw values, so out-of-range settings get through.
  task automatic program_layer(int ch, int nf, int nk, int st, int len);
    write_reg(CFG_CHANNELS, CFG_DATA_W'(ch));
    write_reg(CFG_FILTERS,  CFG_DATA_W'(nf));
    write_reg(CFG_TAPS,     CFG_DATA_W'(nk));
    write_reg(CFG_STRIDE,   CFG_DATA_W'(st));
    write_reg(CFG_LENGTH,   CFG_DATA_W'(len));
    @(negedge clk_i) cfg_we_i <= 1'b0;
    fill_stores();
  endtask

  // Mostly computes on windows that fit and samples inside the used span,
  // with out-of-range positions, stray indexes and store rewrites mixed in.
  task automatic random_items(int count);
    int pmax;
    int span;
    int pick;
    int nf;
    int nk;
    int nch;
    logic [IDXA_W-1:0] ia;
    nf   = sum_board.used_filters();
    nk   = sum_board.used_taps();
    nch  = sum_board.used_channels();
    pmax = -1;
    for (int p = 0; p < 256; p++)
      if (sum_board.window_fits(p)) pmax = p;
    span = int'(sum_board.reg_length) * nch;
    if (span > MAX_SAMPLES_DEF) span = MAX_SAMPLES_DEF;
    if (span < 1) span = 1;
    repeat (count) begin
      // now and then hold off until the block has nothing left to deliver
      if (idle_on && $urandom_range(0, 39) == 0) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (pmax >= 0 && $urandom_range(0, 5) != 0)
          ia = IDXA_W'($urandom_range(0, pmax));
        else
          ia = IDXA_W'($urandom_range(0, 255));
        send_item(OP_COMPUTE, VALUE_W'($urandom), ia, IDXB_W'($urandom), IDXC_W'($urandom));
      end else if (pick < 75) begin
        if ($urandom_range(0, 3) != 0)
          ia = IDXA_W'($urandom_range(0, span - 1));
        else
          ia = IDXA_W'($urandom_range(0, 255));
        send_item(OP_SAMPLE, pick_value(), ia, IDXB_W'($urandom), IDXC_W'($urandom));
      end else if (pick < 88) begin
        if ($urandom_range(0, 3) != 0)
          send_item(OP_WEIGHT, pick_value(), IDXA_W'($urandom_range(0, nf - 1)),
                    IDXB_W'($urandom_range(0, nk - 1)), IDXC_W'($urandom_range(0, nch - 1)));
        else
          send_item(OP_WEIGHT, pick_value(), IDXA_W'($urandom_range(0, 255)),
                    IDXB_W'($urandom), IDXC_W'($urandom));
      end else begin
        if ($urandom_range(0, 3) != 0)
          ia = IDXA_W'($urandom_range(0, nf - 1));
        else
          ia = IDXA_W'($urandom_range(0, 255));
        send_item(OP_BIAS, pick_value(), ia, IDXB_W'($urandom), IDXC_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(int ch, int nf, int nk, int st, int len, int count);
    drain_results();
    program_layer(ch, nf, nk, st, len);
    random_items(count);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sum_board        = new();
    idle_on          = 1'b1;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_WEIGHT;
    in_ch.value      = '0;
    in_ch.index_a    = '0;
    in_ch.index_b    = '0;
    in_ch.index_c    = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // the sample clear after reset holds off the first transfer by itself

    // Registers still at their reset values: one filter, one tap, one
    // channel, length one. The first compute reads a sample never written,
    // so it also checks the cleared sample store.
    send_item(OP_WEIGHT,  VALUE_MAX, 8'd0, 4'd0, 3'd0);
    send_item(OP_BIAS,    VALUE_MIN, 8'd0, 4'd0, 3'd0);
    send_item(OP_COMPUTE, '0, 8'd0, 4'd0, 3'd0);
    send_item(OP_COMPUTE, VALUE_MAX, 8'd1, 4'd15, 3'd7);    // window past length
    send_item(OP_SAMPLE,  VALUE_MIN, 8'd0, 4'd0, 3'd0);
    send_item(OP_WEIGHT,  pick_value(), 8'd255, 4'd15, 3'd7); // filter beyond store
    send_item(OP_BIAS,    VALUE_MAX, 8'd16, 4'd0, 3'd0);      // filter beyond store
    send_item(OP_WEIGHT,  VALUE_MIN, 8'd15, 4'd15, 3'd7);     // last weight entry
    send_item(OP_SAMPLE,  VALUE_MAX, 8'd255, 4'd0, 3'd0);     // last sample entry
    send_item(OP_COMPUTE, '0, 8'd0, 4'd0, 3'd0);              // full-scale product
    send_item(OP_COMPUTE, '0, 8'd255, 4'd0, 3'd0);
    drain_results();

    // writes to undecoded indexes must change nothing
    write_reg(CFG_SPARE_HI, '1);
    write_reg(CFG_SPARE_LO, '0);
    program_layer(2, 3, 2, 1, 8);
    send_item(OP_SAMPLE,  VALUE_MAX, 8'd15, 4'd0, 3'd0);
    send_item(OP_COMPUTE, '0, 8'd3, 4'd0, 3'd0);
    send_item(OP_COMPUTE, '0, 8'd6, 4'd0, 3'd0);              // window ends at length
    send_item(OP_COMPUTE, '0, 8'd7, 4'd0, 3'd0);              // one past
    random_items(10);

    // channels, filters, taps, stride, length, random items
    run_phase(1, 16, 1, 16, 256, 10);   // most filters, stride 16, full length
    run_phase(12, 1, 16, 2, 40, 8);     // channels clamp to eight, most taps
    run_phase(8, 3, 3, 5, 60, 8);
    run_phase(0, 1, 31, 31, 511, 8);    // zero channels, taps clamp, stride beyond 16
    run_phase(4, 2, 2, 1, 0, 5);        // zero length: every compute is out of range
    run_phase(1, 1, 1, 1, 1, 4);
    run_phase(1, 20, 1, 0, 100, 8);     // filters clamp to 16, zero stride acts as one

    // closing stretch at full rate on both channels
    drain_results();
    idle_on = 1'b0;
    program_layer(3, 4, 3, 3, 60);
    random_items(30);
    drain_results();

    sum_board.close_out();
    if (sum_board.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/c1d_pkg.sv
sv/c1d_if.sv
sv/c1d_mem.sv
sv/c1d_mac.sv
sv/conv1d_multichannel_mac.sv
bench/conv1d_sum_board.sv
bench/tb.sv
